// ----- rtl/core/lpmd_pkg.sv -----
// Package for the length-prefixed message deframer.
// Header layout constants, parse phase type and result record.
// No dependencies.
`timescale 1ns / 1ps

package lpmd_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int WORD_W       = 32;
    localparam int BYTE_W       = 8;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HEADER_BYTES - 1);

    typedef enum logic {
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [WORD_W-1:0] message_type;
        logic              has_data;
        logic              first_of_msg;
        logic              last_of_msg;
    } lpmd_result_t;

endpackage

// ----- rtl/core/lpmd_parser.sv -----
// Header/payload parser: holds the framing state and forms one result per
// accepted byte when the byte yields one. Depends on lpmd_pkg.
`timescale 1ns / 1ps

module lpmd_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  byte_accept,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    output lpmd_pkg::lpmd_result_t res
);
    import lpmd_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]  hdr_idx_reg, hdr_idx_next;
    logic [WORD_W-1:0]     length_reg, length_next;
    logic [WORD_W-1:0]     type_reg, type_next;
    logic [WORD_W-1:0]     left_reg, left_next;
    logic                  first_reg, first_next;

    logic                  last_payload;
    logic                  hdr_done;

    assign last_payload = (left_reg[WORD_W-1:1] == '0);
    assign hdr_done     = (hdr_idx_reg == HDR_LAST_IDX);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (byte_accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (hdr_done && (length_reg != '0)) begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (last_payload) begin
                        phase_next = PH_HEADER;
                    end
                end
                default: phase_next = PH_HEADER;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        hdr_idx_next = hdr_idx_reg;
        length_next  = length_reg;
        type_next    = type_reg;
        left_next    = left_reg;
        first_next   = first_reg;
        res_valid    = 1'b0;
        res          = '0;
        res.message_type = type_reg;
        unique case (phase_reg)
            PH_HEADER: begin
                // header byte goes into its lane; idx[2] picks length or type
                unique case (hdr_idx_reg[1:0])
                    2'd0: begin
                        if (hdr_idx_reg[2]) type_next[7:0]   = rx_byte;
                        else                length_next[7:0] = rx_byte;
                    end
                    2'd1: begin
                        if (hdr_idx_reg[2]) type_next[15:8]   = rx_byte;
                        else                length_next[15:8] = rx_byte;
                    end
                    2'd2: begin
                        if (hdr_idx_reg[2]) type_next[23:16]   = rx_byte;
                        else                length_next[23:16] = rx_byte;
                    end
                    default: begin
                        if (hdr_idx_reg[2]) type_next[31:24]   = rx_byte;
                        else                length_next[31:24] = rx_byte;
                    end
                endcase
                if (hdr_done) begin
                    hdr_idx_next = '0;
                    left_next    = length_reg;
                    first_next   = 1'b1;
                    // empty message: marker result
                    res_valid        = byte_accept && (length_reg == '0);
                    res.message_type = type_next;
                    res.first_of_msg = 1'b1;
                    res.last_of_msg  = 1'b1;
                end else begin
                    hdr_idx_next = hdr_idx_reg + HDR_IDX_W'(1);
                end
            end
            PH_PAYLOAD: begin
                res_valid        = byte_accept;
                res.payload_byte = rx_byte;
                res.has_data     = 1'b1;
                res.first_of_msg = first_reg;
                res.last_of_msg  = last_payload;
                first_next       = 1'b0;
                if (last_payload) begin
                    left_next    = '0;
                    hdr_idx_next = '0;
                end else begin
                    left_next = left_reg - WORD_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= '0;
            length_reg  <= '0;
            type_reg    <= '0;
            left_reg    <= '0;
            first_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (byte_accept) begin
                hdr_idx_reg <= hdr_idx_next;
                length_reg  <= length_next;
                type_reg    <= type_next;
                left_reg    <= left_next;
                first_reg   <= first_next;
            end
        end
    end

endmodule

// ----- rtl/core/lpmd_out_reg.sv -----
// Result register: holds one result until the receiver takes it.
// Depends on lpmd_pkg.
`timescale 1ns / 1ps

module lpmd_out_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  logic                   res_valid,
    input  lpmd_pkg::lpmd_result_t res,
    input  logic                   m_ready,
    output logic                   m_valid,
    output lpmd_pkg::lpmd_result_t m_res
);
    import lpmd_pkg::*;

    logic         valid_reg, valid_next;
    lpmd_result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = res_valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = data_reg;

endmodule

// ----- rtl/core/length_prefixed_message_deframer.sv -----
// Top level of the length-prefixed message deframer.
// Instantiates lpmd_parser and lpmd_out_reg; depends on lpmd_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (s_): one raw stream byte per transfer on s_rx_byte.
//   Output channel (m_): one payload byte per transfer, tagged with the
//   message type and first/last marks; an empty message gives one transfer
//   with has_data low, first and last high.
//   Each message is an 8-byte header (32-bit little-endian length, then
//   32-bit little-endian type) followed by length payload bytes. Header
//   bytes give no output transfer except the empty-message marker.
//   Output: a result is registered and appears on m_ in the cycle after its byte is accepted.
//   Throughput: one byte per cycle while the output is not stalled; the
//   parser state updates once per accepted byte, and the result register
//   is reloaded in the same cycle that its held result is taken.
//   Stall: while a result waits and m_ready is low, s_ready drops; no byte
//   is lost or dropped.
//   Reset (aresetn low, synchronous): parser returns to header collection,
//   counters cleared, output register empty.
module length_prefixed_message_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_payload_byte,
    output logic [31:0] m_message_type,
    output logic        m_has_data,
    output logic        m_first_of_msg,
    output logic        m_last_of_msg
);
    import lpmd_pkg::*;

    logic         byte_accept;
    logic         res_valid;
    lpmd_result_t res;
    lpmd_result_t m_res;

    // take a byte when the output slot is free or is emptied this cycle
    assign s_ready     = !m_valid || m_ready;
    assign byte_accept = s_valid && s_ready;

    lpmd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    lpmd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (byte_accept),
        .res_valid (res_valid),
        .res       (res),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_res     (m_res)
    );

    assign m_payload_byte = m_res.payload_byte;
    assign m_message_type = m_res.message_type;
    assign m_has_data     = m_res.has_data;
    assign m_first_of_msg = m_res.first_of_msg;
    assign m_last_of_msg  = m_res.last_of_msg;

endmodule
